// ----- rtl/cbse_pkg.sv -----
package cbse_pkg;

   // fixed field widths
   localparam int COORD_W   = 32;
   localparam int SEG_IDX_W = 4;
   localparam int PT_IDX_W  = 2;
   localparam int CSR_W     = 5;
   localparam int NUM_PTS   = 4;

   // mode field codes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   // saturation limits
   localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

   // one control point as stored: x low, y high
   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

endpackage

// ----- rtl/cbse_ram.sv -----
module cbse_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cubic_bezier_spline_eval.sv -----
// Cubic Bezier spline evaluator, 2D, signed fixed point with FRAC_BITS fraction bits in 32.
// Load transactions (req_mode = 0) write one control point of one segment into four
// point banks, one bank per control point, so a whole segment is read at once; loads
// to a segment at or above SEGMENTS are dropped and produce no response.
// Evaluate transactions (req_mode = 1) split req_param_w into segment (integer part) and
// tt (fraction); a negative parameter maps to segment 0 at tt = 0, a parameter at or past
// the last segment in use maps to that segment at tt = 1, both raising param_clamped.
// Each evaluate returns position, first and second derivative in x and y, rounded half
// up and saturated to 32 bits, with overflow set if any of the six saturated.
// Throughput is one transaction per clock while rsp_stall stays low: the datapath is six
// register stages (bank read, basis squares, basis cubes and derivative products,
// position products and derivative sums, position sum and derivative rounding, position
// rounding), each about one multiplier deep. Stages advance independently; a stalled
// response holds only the stages behind it that are full, and bubbles are squeezed out.
// csr_wr_data sets the number of segments in use (0 reads as 1, values above SEGMENTS as
// SEGMENTS); write it only with the pipeline empty. Control points read back undefined
// until loaded.
module cubic_bezier_spline_eval #(
   parameter int SEGMENTS  = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic        [cbse_pkg::SEG_IDX_W-1:0] req_segment_index,
   input  logic        [cbse_pkg::PT_IDX_W-1:0]  req_point_index,
   input  logic signed [cbse_pkg::COORD_W-1:0]   req_point_x,
   input  logic signed [cbse_pkg::COORD_W-1:0]   req_point_y,
   input  logic signed [cbse_pkg::COORD_W-1:0]   req_param_w,
   // segment count register
   input  logic                                 csr_wr_en,
   input  logic        [cbse_pkg::CSR_W-1:0]     csr_wr_data,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [cbse_pkg::COORD_W-1:0]   rsp_pos_x,
   output logic signed [cbse_pkg::COORD_W-1:0]   rsp_pos_y,
   output logic signed [cbse_pkg::COORD_W-1:0]   rsp_vel_x,
   output logic signed [cbse_pkg::COORD_W-1:0]   rsp_vel_y,
   output logic signed [cbse_pkg::COORD_W-1:0]   rsp_acc_x,
   output logic signed [cbse_pkg::COORD_W-1:0]   rsp_acc_y,
   output logic                                 rsp_param_clamped,
   output logic                                 rsp_overflow
);

   localparam int CW     = cbse_pkg::COORD_W;
   localparam int NP     = cbse_pkg::NUM_PTS;
   localparam int F      = FRAC_BITS;
   localparam int SEG_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int CNT_W  = 9;            // holds counts up to 511
   localparam int NSTG   = 6;
   localparam int TT_W   = F + 1;        // tt, u, uu, ut, t2 in [0, ONE]
   localparam int PRD_W  = 2 * F + 2;    // product of two TT_W values plus rounding
   localparam int B_W    = F + 3;        // basis weights, up to 3*ONE
   localparam int DIF_W  = CW + 1;       // first differences of points
   localparam int DD_W   = CW + 2;       // second differences of points
   localparam int PV_W   = TT_W + 1 + DIF_W;
   localparam int PA_W   = TT_W + 1 + DD_W;
   localparam int PP_W   = B_W + 1 + CW;
   localparam int SUM_W  = F + 38;       // exact sums before final scaling

   localparam logic [CNT_W-1:0] SEG_MAX = CNT_W'(SEGMENTS);
   localparam logic [TT_W-1:0]  ONE_TT  = TT_W'(1) << F;
   localparam logic [PRD_W-1:0] HALF_P  = PRD_W'(1) << (F - 1);
   localparam logic signed [SUM_W:0] HALF_S = $signed((SUM_W + 1)'(1) << (F - 1));

   // rnd(a) = (a + ONE/2) >> F for a non-negative product of two [0, ONE] values
   function automatic logic [TT_W-1:0] rnd_fx(input logic [PRD_W-1:0] p);
      logic [PRD_W-1:0] s;
      s = (p + HALF_P) >> F;
      return s[TT_W-1:0];
   endfunction

   // floor((x + ONE/2) / ONE), saturated; returns {saturated, value}
   function automatic logic [CW:0] finish_fx(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W:0]   s;
      logic [SUM_W-CW+1:0]     hi;
      logic                    sat;
      logic [CW-1:0]           v;
      s   = (SUM_W + 1)'(x) + HALF_S;
      s   = s >>> F;
      hi  = s[SUM_W:CW-1];
      sat = !((hi == '0) || (hi == '1));
      if (sat) begin
         v = s[SUM_W] ? cbse_pkg::SAT_MIN : cbse_pkg::SAT_MAX;
      end else begin
         v = s[CW-1:0];
      end
      return {sat, v};
   endfunction

   // ---------------------------------------------------------------- control
   logic [CNT_W-1:0] seg_cnt_ff, seg_cnt_in;   // effective segment count, clamped on write
   logic [NSTG-1:0]  stg_vld_ff, stg_vld_in;
   logic [NSTG-1:0]  stg_rdy;
   logic             req_accept, eval_acc, load_acc;

   always_comb begin
      seg_cnt_in = seg_cnt_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            seg_cnt_in = CNT_W'(1);
         end else if (CNT_W'(csr_wr_data) > SEG_MAX) begin
            seg_cnt_in = SEG_MAX;
         end else begin
            seg_cnt_in = CNT_W'(csr_wr_data);
         end
      end
   end

   // a stage can take new data when it is empty or its own contents move on
   always_comb begin
      stg_rdy[NSTG-1] = !stg_vld_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         stg_rdy[k] = !stg_vld_ff[k] || stg_rdy[k+1];
      end
   end

   assign req_stall  = !stg_rdy[0];
   assign req_accept = req_valid && !req_stall;
   assign eval_acc   = req_accept && (req_mode == cbse_pkg::MODE_EVAL);
   assign load_acc   = req_accept && (req_mode == cbse_pkg::MODE_LOAD)
                       && (CNT_W'(req_segment_index) < SEG_MAX);

   always_comb begin
      stg_vld_in[0] = stg_rdy[0] ? eval_acc : stg_vld_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         stg_vld_in[k] = stg_rdy[k] ? stg_vld_ff[k-1] : stg_vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_cnt_ff <= CNT_W'(1);
         stg_vld_ff <= '0;
      end else begin
         seg_cnt_ff <= seg_cnt_in;
         stg_vld_ff <= stg_vld_in;
      end
   end

   // ---------------------------------------------------- parameter decode
   logic [CW-1:0]    w_int;
   logic             w_neg, w_over;
   logic [CNT_W-1:0] seg_last, ld_seg;
   logic [SEG_W-1:0] rd_seg, wr_seg;
   logic [TT_W-1:0]  tt0_in;
   logic             clp0_in;

   always_comb begin
      w_int    = {1'b0, req_param_w[CW-2:0]} >> F;
      w_neg    = req_param_w[CW-1];
      w_over   = !w_neg && (w_int >= CW'(seg_cnt_ff));
      seg_last = seg_cnt_ff - CNT_W'(1);
      ld_seg   = CNT_W'(req_segment_index);
      wr_seg   = ld_seg[SEG_W-1:0];
      if (w_neg) begin
         rd_seg  = '0;
         tt0_in  = '0;
         clp0_in = 1'b1;
      end else if (w_over) begin
         rd_seg  = seg_last[SEG_W-1:0];
         tt0_in  = ONE_TT;
         clp0_in = 1'b1;
      end else begin
         rd_seg  = w_int[SEG_W-1:0];
         tt0_in  = {1'b0, req_param_w[F-1:0]};
         clp0_in = 1'b0;
      end
   end

   // ------------------------------------------------ stage 0: bank read
   cbse_pkg::point_type ram_q [NP];

   for (genvar k = 0; k < NP; k++) begin : g_bank
      cbse_ram #(
         .WIDTH ($bits(cbse_pkg::point_type)),
         .DEPTH (SEGMENTS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (load_acc && (req_point_index == cbse_pkg::PT_IDX_W'(k))),
         .wr_addr (wr_seg),
         .wr_data ({req_point_y, req_point_x}),
         .rd_en   (eval_acc),
         .rd_addr (rd_seg),
         .rd_data (ram_q[k])
      );
   end

   logic [TT_W-1:0] tt0_ff;
   logic            clp0_ff;

   always_ff @(posedge clock) begin
      if (stg_rdy[0]) begin
         tt0_ff  <= tt0_in;
         clp0_ff <= clp0_in;
      end
   end

   // ------------------------------ stage 1: basis squares, point differences
   logic signed [CW-1:0]    pt0 [NP][2];
   logic [TT_W-1:0]         u1_in, uu1_in, ut1_in, t21_in;
   logic signed [DIF_W-1:0] dif1_in [3][2];
   logic signed [DD_W-1:0]  ddf1_in [2][2];

   logic [TT_W-1:0]         tt1_ff, u1_ff, uu1_ff, ut1_ff, t21_ff;
   logic signed [DIF_W-1:0] dif1_ff [3][2];
   logic signed [DD_W-1:0]  ddf1_ff [2][2];
   logic signed [CW-1:0]    pts1_ff [NP][2];
   logic                    clp1_ff;

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         pt0[k][0] = ram_q[k].x;
         pt0[k][1] = ram_q[k].y;
      end
      u1_in  = ONE_TT - tt0_ff;
      uu1_in = rnd_fx(PRD_W'(u1_in) * PRD_W'(u1_in));
      ut1_in = rnd_fx(PRD_W'(u1_in) * PRD_W'(tt0_ff));
      t21_in = rnd_fx(PRD_W'(tt0_ff) * PRD_W'(tt0_ff));
      for (int a = 0; a < 2; a++) begin
         for (int k = 0; k < 3; k++) begin
            dif1_in[k][a] = DIF_W'(pt0[k+1][a]) - DIF_W'(pt0[k][a]);
         end
         for (int k = 0; k < 2; k++) begin
            ddf1_in[k][a] = DD_W'(pt0[k+2][a]) - DD_W'(pt0[k+1][a])
                            - DD_W'(pt0[k+1][a]) + DD_W'(pt0[k][a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[1]) begin
         tt1_ff  <= tt0_ff;
         u1_ff   <= u1_in;
         uu1_ff  <= uu1_in;
         ut1_ff  <= ut1_in;
         t21_ff  <= t21_in;
         dif1_ff <= dif1_in;
         ddf1_ff <= ddf1_in;
         pts1_ff <= pt0;
         clp1_ff <= clp0_ff;
      end
   end

   // -------------------- stage 2: basis cubes, derivative products
   logic [B_W-1:0]         b2_in [NP];
   logic [B_W-1:0]         r1, r2;
   logic signed [PV_W-1:0] pv2_in [3][2];
   logic signed [PA_W-1:0] pa2_in [2][2];

   logic [B_W-1:0]         b2_ff [NP];
   logic signed [PV_W-1:0] pv2_ff [3][2];
   logic signed [PA_W-1:0] pa2_ff [2][2];
   logic signed [CW-1:0]   pts2_ff [NP][2];
   logic                   clp2_ff;

   always_comb begin
      r1       = B_W'(rnd_fx(PRD_W'(uu1_ff) * PRD_W'(tt1_ff)));
      r2       = B_W'(rnd_fx(PRD_W'(t21_ff) * PRD_W'(u1_ff)));
      b2_in[0] = B_W'(rnd_fx(PRD_W'(uu1_ff) * PRD_W'(u1_ff)));
      b2_in[1] = (r1 << 1) + r1;
      b2_in[2] = (r2 << 1) + r2;
      b2_in[3] = B_W'(rnd_fx(PRD_W'(t21_ff) * PRD_W'(tt1_ff)));
      for (int a = 0; a < 2; a++) begin
         pv2_in[0][a] = PV_W'($signed({1'b0, uu1_ff})) * PV_W'(dif1_ff[0][a]);
         pv2_in[1][a] = PV_W'($signed({1'b0, ut1_ff})) * PV_W'(dif1_ff[1][a]);
         pv2_in[2][a] = PV_W'($signed({1'b0, t21_ff})) * PV_W'(dif1_ff[2][a]);
         pa2_in[0][a] = PA_W'($signed({1'b0, u1_ff}))  * PA_W'(ddf1_ff[0][a]);
         pa2_in[1][a] = PA_W'($signed({1'b0, tt1_ff})) * PA_W'(ddf1_ff[1][a]);
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[2]) begin
         b2_ff   <= b2_in;
         pv2_ff  <= pv2_in;
         pa2_ff  <= pa2_in;
         pts2_ff <= pts1_ff;
         clp2_ff <= clp1_ff;
      end
   end

   // ------------ stage 3: position products, derivative weighted sums
   logic signed [PP_W-1:0]  pp3_in [NP][2];
   logic signed [SUM_W-1:0] vs3_in [2], as3_in [2];
   logic signed [SUM_W-1:0] v0, v1, v2, sa;

   logic signed [PP_W-1:0]  pp3_ff [NP][2];
   logic signed [SUM_W-1:0] vs3_ff [2], as3_ff [2];
   logic                    clp3_ff;

   always_comb begin
      v0 = '0;
      v1 = '0;
      v2 = '0;
      sa = '0;
      for (int a = 0; a < 2; a++) begin
         for (int k = 0; k < NP; k++) begin
            pp3_in[k][a] = PP_W'($signed({1'b0, b2_ff[k]})) * PP_W'(pts2_ff[k][a]);
         end
         v0 = SUM_W'(pv2_ff[0][a]);
         v1 = SUM_W'(pv2_ff[1][a]);
         v2 = SUM_W'(pv2_ff[2][a]);
         // 3*v0 + 6*v1 + 3*v2
         vs3_in[a] = (v0 <<< 1) + v0 + (v1 <<< 2) + (v1 <<< 1) + (v2 <<< 1) + v2;
         sa = SUM_W'(pa2_ff[0][a]) + SUM_W'(pa2_ff[1][a]);
         as3_in[a] = (sa <<< 2) + (sa <<< 1);
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[3]) begin
         pp3_ff  <= pp3_in;
         vs3_ff  <= vs3_in;
         as3_ff  <= as3_in;
         clp3_ff <= clp2_ff;
      end
   end

   // ------------- stage 4: position sum, derivative rounding and saturation
   logic signed [SUM_W-1:0] ps4_in [2];
   logic [CW:0]             fv, fa;
   logic signed [CW-1:0]    vel4_in [2], acc4_in [2];
   logic                    ovf4_in;

   logic signed [SUM_W-1:0] ps4_ff [2];
   logic signed [CW-1:0]    vel4_ff [2], acc4_ff [2];
   logic                    ovf4_ff, clp4_ff;

   always_comb begin
      ovf4_in = 1'b0;
      fv      = '0;
      fa      = '0;
      for (int a = 0; a < 2; a++) begin
         ps4_in[a] = SUM_W'(pp3_ff[0][a]) + SUM_W'(pp3_ff[1][a])
                     + SUM_W'(pp3_ff[2][a]) + SUM_W'(pp3_ff[3][a]);
         fv = finish_fx(vs3_ff[a]);
         fa = finish_fx(as3_ff[a]);
         vel4_in[a] = fv[CW-1:0];
         acc4_in[a] = fa[CW-1:0];
         ovf4_in = ovf4_in | fv[CW] | fa[CW];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[4]) begin
         ps4_ff  <= ps4_in;
         vel4_ff <= vel4_in;
         acc4_ff <= acc4_in;
         ovf4_ff <= ovf4_in;
         clp4_ff <= clp3_ff;
      end
   end

   // ------------------------- stage 5: position rounding, output register
   logic [CW:0]          fpx, fpy;
   logic signed [CW-1:0] pos5_ff [2], vel5_ff [2], acc5_ff [2];
   logic                 ovf5_ff, clp5_ff;

   assign fpx = finish_fx(ps4_ff[0]);
   assign fpy = finish_fx(ps4_ff[1]);

   always_ff @(posedge clock) begin
      if (stg_rdy[5]) begin
         pos5_ff[0] <= fpx[CW-1:0];
         pos5_ff[1] <= fpy[CW-1:0];
         vel5_ff    <= vel4_ff;
         acc5_ff    <= acc4_ff;
         ovf5_ff    <= ovf4_ff | fpx[CW] | fpy[CW];
         clp5_ff    <= clp4_ff;
      end
   end

   assign rsp_valid         = stg_vld_ff[NSTG-1];
   assign rsp_pos_x         = pos5_ff[0];
   assign rsp_pos_y         = pos5_ff[1];
   assign rsp_vel_x         = vel5_ff[0];
   assign rsp_vel_y         = vel5_ff[1];
   assign rsp_acc_x         = acc5_ff[0];
   assign rsp_acc_y         = acc5_ff[1];
   assign rsp_param_clamped = clp5_ff;
   assign rsp_overflow      = ovf5_ff;

   // ------------------------------------------------------------ checks
   // requests only back up when every stage is full and the response is stalled
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stg_vld_ff == '1) && rsp_stall)
      else $error("request stalled with room in the pipeline");

   // an accepted evaluate always lands in the first stage
   a_eval_enters : assert property (@(posedge clock) disable iff (reset)
      eval_acc |=> stg_vld_ff[0])
      else $error("evaluate transaction lost at pipeline entry");

   // clamped parameters only ever give an end point of the segment
   a_clamp_tt : assert property (@(posedge clock) disable iff (reset)
      stg_vld_ff[0] && clp0_ff |-> (tt0_ff == '0) || (tt0_ff == ONE_TT))
      else $error("clamped parameter with interior tt");

   // segment count stays within the table
   a_seg_cnt : assert property (@(posedge clock) disable iff (reset)
      (seg_cnt_ff != '0) && (seg_cnt_ff <= SEG_MAX))
      else $error("segment count out of range");

endmodule

// ----- tb/tb_cubic_bezier_spline_eval.sv -----
`timescale 1ns / 100ps

module tb_cubic_bezier_spline_eval;

   // must match the DUT instance parameters below
   localparam int SEG_COUNT    = 16;
   localparam int FRAC         = 16;
   localparam int RESET_CYCLES = 4;
   localparam int DRAIN_CYCLES = 12;    // idle wait at the end of settle()
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int QUIET_LIMIT  = 3000;  // cycles with no transaction on either side
   localparam int REPORT_MAX   = 10;

   localparam longint ONE_Q  = longint'(1) << FRAC;
   localparam longint HALF_Q = longint'(1) << (FRAC - 1);
   localparam longint LIM_HI = (longint'(1) << 31) - 1;
   localparam longint LIM_LO = -(longint'(1) << 31);

   typedef logic signed [cbse_pkg::COORD_W-1:0] coord_type;

   // one request transaction as offered on the req_ channel
   typedef struct {
      logic                           mode;
      logic [cbse_pkg::SEG_IDX_W-1:0] seg;
      logic [cbse_pkg::PT_IDX_W-1:0]  pt;
      coord_type                      x;
      coord_type                      y;
      coord_type                      w;
   } curve_req_type;

   // one response transaction: position, derivatives, flags
   typedef struct packed {
      coord_type pos_x;
      coord_type pos_y;
      coord_type vel_x;
      coord_type vel_y;
      coord_type acc_x;
      coord_type acc_y;
      logic      clamped;
      logic      ovf;
   } curve_sample_type;

   // ---------------------------------------------------------------------------------
   // clock, reset, DUT
   // ---------------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   logic                           req_valid         = 1'b0;
   logic                           req_stall;
   logic                           req_mode          = cbse_pkg::MODE_LOAD;
   logic [cbse_pkg::SEG_IDX_W-1:0] req_segment_index = '0;
   logic [cbse_pkg::PT_IDX_W-1:0]  req_point_index   = '0;
   coord_type                      req_point_x       = '0;
   coord_type                      req_point_y       = '0;
   coord_type                      req_param_w       = '0;
   logic                           csr_wr_en         = 1'b0;
   logic [cbse_pkg::CSR_W-1:0]     csr_wr_data       = '0;
   logic                           rsp_valid;
   logic                           rsp_stall         = 1'b0;
   coord_type                      rsp_pos_x;
   coord_type                      rsp_pos_y;
   coord_type                      rsp_vel_x;
   coord_type                      rsp_vel_y;
   coord_type                      rsp_acc_x;
   coord_type                      rsp_acc_y;
   logic                           rsp_param_clamped;
   logic                           rsp_overflow;

   cubic_bezier_spline_eval #(
      .SEGMENTS  (SEG_COUNT),
      .FRAC_BITS (FRAC)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_segment_index (req_segment_index),
      .req_point_index   (req_point_index),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_param_w       (req_param_w),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_vel_x         (rsp_vel_x),
      .rsp_vel_y         (rsp_vel_y),
      .rsp_acc_x         (rsp_acc_x),
      .rsp_acc_y         (rsp_acc_y),
      .rsp_param_clamped (rsp_param_clamped),
      .rsp_overflow      (rsp_overflow)
   );

   // ---------------------------------------------------------------------------------
   // spline predictor: own copy of the point table and the segment count register
   // ---------------------------------------------------------------------------------
   cbse_pkg::point_type        ctrl_pts [SEG_COUNT*cbse_pkg::NUM_PTS];  // segment*4 + point
   logic [cbse_pkg::CSR_W-1:0] seg_count_reg = 5'd1;                   // reset value

   curve_req_type    curve_requests[$];     // not yet offered to the DUT
   curve_sample_type predicted_samples[$];  // accepted evaluates awaiting a response
   int               mismatch_count = 0;

   // 0 acts as 1, anything past the table size as the table size
   function automatic int effective_segments(logic [cbse_pkg::CSR_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > SEG_COUNT)
         return SEG_COUNT;
      return int'(v);
   endfunction

   // divide by ONE, round half toward +inf (floor of x + ONE/2)
   function automatic longint scale_round(longint a);
      return (a + HALF_Q) >>> FRAC;
   endfunction

   function automatic coord_type saturate_q(longint a, inout logic ovf);
      longint r;
      r = scale_round(a);
      if (r > LIM_HI) begin
         r   = LIM_HI;
         ovf = 1'b1;
      end
      if (r < LIM_LO) begin
         r   = LIM_LO;
         ovf = 1'b1;
      end
      return r[cbse_pkg::COORD_W-1:0];
   endfunction

   function automatic curve_sample_type eval_bezier(coord_type w);
      int               eff;
      int               seg;
      int               i;
      longint           tt, u, uu, ut, t2, sx, sy;
      longint           wt [cbse_pkg::NUM_PTS];
      longint           px [cbse_pkg::NUM_PTS];
      longint           py [cbse_pkg::NUM_PTS];
      logic             ovf;
      curve_sample_type s;
      eff = effective_segments(seg_count_reg);
      s   = '0;
      ovf = 1'b0;
      // negative w pins to the start of segment 0
      if (w < 0) begin
         seg       = 0;
         tt        = 0;
         s.clamped = 1'b1;
      end else begin
         seg = int'(w[cbse_pkg::COORD_W-2:FRAC]);
         tt  = longint'(w[FRAC-1:0]);
         // at or past the end: last segment in use, tt = 1.0
         if (seg >= eff) begin
            seg       = eff - 1;
            tt        = ONE_Q;
            s.clamped = 1'b1;
         end
      end
      for (i = 0; i < cbse_pkg::NUM_PTS; i++) begin
         px[i] = ctrl_pts[seg*cbse_pkg::NUM_PTS + i].x;
         py[i] = ctrl_pts[seg*cbse_pkg::NUM_PTS + i].y;
      end

      u  = ONE_Q - tt;
      uu = scale_round(u * u);
      ut = scale_round(u * tt);
      t2 = scale_round(tt * tt);
      wt[0] = scale_round(uu * u);
      wt[1] = 3 * scale_round(uu * tt);
      wt[2] = 3 * scale_round(t2 * u);
      wt[3] = scale_round(t2 * tt);

      sx = 0;
      sy = 0;
      for (i = 0; i < cbse_pkg::NUM_PTS; i++) begin
         sx += wt[i] * px[i];
         sy += wt[i] * py[i];
      end
      s.pos_x = saturate_q(sx, ovf);
      s.pos_y = saturate_q(sy, ovf);

      sx = 3*uu*(px[1] - px[0]) + 6*ut*(px[2] - px[1]) + 3*t2*(px[3] - px[2]);
      sy = 3*uu*(py[1] - py[0]) + 6*ut*(py[2] - py[1]) + 3*t2*(py[3] - py[2]);
      s.vel_x = saturate_q(sx, ovf);
      s.vel_y = saturate_q(sy, ovf);

      sx = 6*u*(px[2] - 2*px[1] + px[0]) + 6*tt*(px[3] - 2*px[2] + px[1]);
      sy = 6*u*(py[2] - 2*py[1] + py[0]) + 6*tt*(py[3] - 2*py[2] + py[1]);
      s.acc_x = saturate_q(sx, ovf);
      s.acc_y = saturate_q(sy, ovf);

      s.ovf = ovf;
      return s;
   endfunction

   // ---------------------------------------------------------------------------------
   // request driver: pops the next transaction, random gaps between transactions
   // ---------------------------------------------------------------------------------

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      if (pick < 85)
         return $urandom_range(1, 3);
      if (pick < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   curve_req_type on_port;
   int            gap_left    = 0;
   int            steady_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predictor follows the DUT in acceptance order
         if (req_valid && !req_stall) begin
            if (on_port.mode == cbse_pkg::MODE_EVAL)
               predicted_samples.push_back(eval_bezier(on_port.w));
            else
               ctrl_pts[{on_port.seg, on_port.pt}] = {on_port.y, on_port.x};
         end
         // a held transaction stays put until accepted
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (curve_requests.size() > 0) begin
               on_port = curve_requests.pop_front();
               req_valid         <= 1'b1;
               req_mode          <= on_port.mode;
               req_segment_index <= on_port.seg;
               req_point_index   <= on_port.pt;
               req_point_x       <= on_port.x;
               req_point_y       <= on_port.y;
               req_param_w       <= on_port.w;
               // gap after this one; occasional back-to-back stretches
               if (steady_left > 0) begin
                  steady_left--;
                  gap_left = 0;
               end else begin
                  gap_left = idle_len();
                  if ($urandom_range(0, 49) == 0)
                     steady_left = $urandom_range(20, 80);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // response monitor: checks each response against the oldest prediction and
   // drives rsp_stall (random stalls plus two long hold-offs)
   // ---------------------------------------------------------------------------------
   int checked_count = 0;
   int held_at       = -1;
   int hold_left     = 0;
   int stall_left    = 0;
   int open_left     = 0;

   always @(posedge clock) begin : rsp_monitor
      curve_sample_type got;
      curve_sample_type want;
      string            bad;
      logic             stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_pos_x, rsp_pos_y, rsp_vel_x, rsp_vel_y, rsp_acc_x, rsp_acc_y,
                   rsp_param_clamped, rsp_overflow};
            if (predicted_samples.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: response with no evaluate pending: %h", $time, got);
            end else begin
               want = predicted_samples.pop_front();
               bad  = "";
               if (got.pos_x !== want.pos_x)     bad = {bad, " pos_x"};
               if (got.pos_y !== want.pos_y)     bad = {bad, " pos_y"};
               if (got.vel_x !== want.vel_x)     bad = {bad, " vel_x"};
               if (got.vel_y !== want.vel_y)     bad = {bad, " vel_y"};
               if (got.acc_x !== want.acc_x)     bad = {bad, " acc_x"};
               if (got.acc_y !== want.acc_y)     bad = {bad, " acc_y"};
               if (got.clamped !== want.clamped) bad = {bad, " param_clamped"};
               if (got.ovf !== want.ovf)         bad = {bad, " overflow"};
               if (bad != "") begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX) begin
                     $display("%0t: response %0d differs in%s", $time, checked_count, bad);
                     $display("   exp pos %h %h vel %h %h acc %h %h clamp %b ovf %b",
                              want.pos_x, want.pos_y, want.vel_x, want.vel_y,
                              want.acc_x, want.acc_y, want.clamped, want.ovf);
                     $display("   got pos %h %h vel %h %h acc %h %h clamp %b ovf %b",
                              got.pos_x, got.pos_y, got.vel_x, got.vel_y,
                              got.acc_x, got.acc_y, got.clamped, got.ovf);
                  end
               end
            end
            checked_count++;
         end

         // hold-off at two points of the run: the pipeline fills and req_stall rises
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if ((checked_count == 150 || checked_count == 800) &&
                      held_at != checked_count) begin
            held_at    = checked_count;
            hold_left  = HOLD_CYCLES - 1;
            stall_next = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (open_left > 0) begin
            open_left--;
            stall_next = 1'b0;
         end else begin
            stall_left = idle_len();
            open_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(0, 6);
            stall_next = (stall_left > 0);
            if (stall_left > 0)
               stall_left--;
         end
         rsp_stall <= stall_next;
      end
   end

   // ---------------------------------------------------------------------------------
   // watchdog: no transaction on either channel for too long
   // ---------------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------------

   // full-range, saturating extremes, or moderate values that keep outputs in range
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return $signed(cbse_pkg::SAT_MAX);
         2:       return $signed(cbse_pkg::SAT_MIN);
         default: return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      endcase
   endfunction

   // mostly inside the segments in use, plus negative, past-the-end and boundaries
   function automatic coord_type rand_param(int eff);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 72)
         return {16'($urandom_range(0, eff - 1)), 16'($urandom())};
      if (pick < 80)
         return $urandom() | 32'h8000_0000;
      if (pick < 88)
         return {16'($urandom_range(eff, 32767)), 16'($urandom())};
      if (pick < 94)
         return {16'(eff - $urandom_range(0, 1)),
                 ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000};
      return $urandom();
   endfunction

   // unused fields still get random bits
   function automatic void push_load(int seg, int pt, coord_type x, coord_type y);
      curve_req_type r;
      r.mode = cbse_pkg::MODE_LOAD;
      r.seg  = seg[cbse_pkg::SEG_IDX_W-1:0];
      r.pt   = pt[cbse_pkg::PT_IDX_W-1:0];
      r.x    = x;
      r.y    = y;
      r.w    = $urandom();
      curve_requests.push_back(r);
   endfunction

   function automatic void push_eval(coord_type w);
      curve_req_type r;
      r.mode = cbse_pkg::MODE_EVAL;
      r.seg  = cbse_pkg::SEG_IDX_W'($urandom());
      r.pt   = cbse_pkg::PT_IDX_W'($urandom());
      r.x    = $urandom();
      r.y    = $urandom();
      r.w    = w;
      curve_requests.push_back(r);
   endfunction

   // all offered, all answered, then DRAIN_CYCLES more idle clocks
   task automatic settle();
      do
         @(negedge clock);
      while (curve_requests.size() != 0 || req_valid || predicted_samples.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // only called with the DUT idle
   task automatic set_segments(logic [cbse_pkg::CSR_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      seg_count_reg = v;
   endtask

   initial begin : stimulus
      int        s, p, n, k, eff, phase, budget, pick;
      coord_type px, py;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      set_segments(5'd16);

      // fill the whole table first so no evaluate ever reads an unwritten point
      //   seg 0: alternating extremes, derivatives saturate
      //   seg 1: small exact values
      //   seg 15: every point at the corner, position sits on the limit
      for (s = 0; s < SEG_COUNT; s++) begin
         for (p = 0; p < cbse_pkg::NUM_PTS; p++) begin
            case (s)
               0: begin
                  px = p[0] ? $signed(cbse_pkg::SAT_MIN) : $signed(cbse_pkg::SAT_MAX);
                  py = p[0] ? $signed(cbse_pkg::SAT_MAX) : $signed(cbse_pkg::SAT_MIN);
               end
               1: begin
                  px = p * 32'sh0001_0000;
                  py = (p == 2) ? -32'sh0001_0000 : p * 32'sh0002_0000;
               end
               15: begin
                  px = $signed(cbse_pkg::SAT_MAX);
                  py = $signed(cbse_pkg::SAT_MIN);
               end
               default: begin
                  px = rand_coord();
                  py = rand_coord();
               end
            endcase
            push_load(s, p, px, py);
         end
      end

      // directed evaluates, all 16 segments in use
      push_eval(32'h0000_0000);   // start of seg 0, exact p0
      push_eval(32'h0000_8000);   // mid seg 0, overflow
      push_eval(32'h0000_FFFF);   // largest fraction
      push_eval(32'h0001_0000);   // seg 1 start
      push_eval(32'h0001_8000);   // seg 1 middle
      push_eval(32'h000F_8000);   // last segment, corner points
      push_eval(32'h000F_FFFF);   // last point before the end
      push_eval(32'h0010_0000);   // exactly at the end: clamps
      push_eval(32'h7FFF_FFFF);   // largest w: clamps
      push_eval(32'hFFFF_FFFF);   // smallest negative: clamps to start
      push_eval(32'h8000_0000);   // most negative w
      settle();

      // single segment: anything from 1.0 up clamps to seg 0 at tt = 1
      set_segments(5'd1);
      push_eval(32'h0000_C000);
      push_eval(32'h0001_0000);
      push_eval(32'hFFFF_0000);
      settle();

      // zero reads as one segment
      set_segments(5'd0);
      push_eval(32'h0000_4000);
      push_eval(32'h0002_0000);
      settle();

      // register maximum reads as the table size
      set_segments(5'd31);
      push_eval(32'h000F_8000);
      push_eval(32'h0010_0000);
      push_eval(32'h0011_0000);
      settle();

      // random phases, each under its own segment count
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       set_segments(5'd16);
            1:       set_segments(5'd1);
            2:       set_segments(5'($urandom_range(2, 15)));
            3:       set_segments(5'($urandom_range(17, 31)));
            default: set_segments(5'($urandom_range(0, 31)));
         endcase
         eff    = effective_segments(seg_count_reg);
         budget = 0;
         while (budget < 280) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               // reload a whole segment, then sample it
               s = $urandom_range(0, SEG_COUNT - 1);
               for (p = 0; p < cbse_pkg::NUM_PTS; p++)
                  push_load(s, p, rand_coord(), rand_coord());
               n = $urandom_range(2, 5);
               for (k = 0; k < n; k++) begin
                  if (s < eff)
                     push_eval({16'(s), 16'($urandom())});
                  else
                     push_eval(rand_param(eff));
               end
               budget += cbse_pkg::NUM_PTS + n;
            end else if (pick < 40) begin
               push_load($urandom_range(0, SEG_COUNT - 1),
                         $urandom_range(0, cbse_pkg::NUM_PTS - 1),
                         rand_coord(), rand_coord());
               budget++;
            end else begin
               push_eval(rand_param(eff));
               budget++;
            end
         end
         settle();
      end

      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/cbse_pkg.sv
rtl/cbse_ram.sv
rtl/cubic_bezier_spline_eval.sv
tb/tb_cubic_bezier_spline_eval.sv
